// ===== hw/rtl/ccp_pkg.sv =====
package ccp_pkg;

	// field widths
	localparam int COEF_W = 13;
	localparam int BYTE_W = 8;
	localparam int BUF_W  = 17;
	localparam int CNT_W  = 5;

	// compressed widths per mode
	localparam int WIDE_BITS   = 10;
	localparam int NARROW_BITS = 3;
	localparam int VAL_W       = WIDE_BITS;

	localparam logic [VAL_W-1:0] WIDE_MASK   = 10'h3FF;
	localparam logic [VAL_W-1:0] NARROW_MASK = 10'h007;

	// compression mode
	typedef enum logic {
		MODE_WIDE   = 1'b0,
		MODE_NARROW = 1'b1
	} mode_t;

	// compressed value handed to the packer
	typedef struct packed {
		logic             valid;
		mode_t            mode;
		logic [VAL_W-1:0] value;
	} cval_t;

endpackage

// ===== hw/rtl/ccp_compress.sv =====
module ccp_compress #(
	parameter int MODULUS = 7681
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ccp_pkg::COEF_W-1:0] coefficient,
	input  ccp_pkg::mode_t             mode,
	output ccp_pkg::cval_t             cval,
	input  logic                       take
);

	// reciprocal of the modulus, exact for every numerator that can occur
	localparam longint unsigned HALF = longint'(MODULUS / 2);
	localparam longint unsigned NUM_MAX =
		(((64'd1 << ccp_pkg::COEF_W) - 64'd1) << ccp_pkg::WIDE_BITS) + HALF;
	localparam int NUM_W   = $clog2(NUM_MAX + 64'd1);
	localparam int K       = NUM_W + $clog2(MODULUS);
	localparam longint unsigned RECIP =
		((64'd1 << K) + longint'(MODULUS) - 64'd1) / longint'(MODULUS);
	localparam int RECIP_W = $clog2(RECIP + 64'd1);
	localparam int PROD_W  = NUM_W + RECIP_W;

	logic                       valid_s1;
	logic [ccp_pkg::COEF_W-1:0] coef_s1;
	ccp_pkg::mode_t             mode_s1;

	logic                       valid_s2;
	ccp_pkg::mode_t             mode_s2;
	logic [ccp_pkg::VAL_W-1:0]  value_s2;

	logic                       adv_s1;
	logic                       adv_s2;
	logic [NUM_W-1:0]           num;
	logic [PROD_W-1:0]          product;
	logic [ccp_pkg::VAL_W-1:0]  quot;
	logic [ccp_pkg::VAL_W-1:0]  value;

	// pipeline advance
	assign adv_s2   = !valid_s2 || take;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// numerator, reciprocal multiply and mask to d bits
	always_comb begin
		if (mode_s1 == ccp_pkg::MODE_NARROW) begin
			num = NUM_W'({coef_s1, {ccp_pkg::NARROW_BITS{1'b0}}});
		end else begin
			num = NUM_W'({coef_s1, {ccp_pkg::WIDE_BITS{1'b0}}});
		end
		num     = num + NUM_W'(HALF);
		product = PROD_W'(num) * PROD_W'(RECIP_W'(RECIP));
		quot    = product[K +: ccp_pkg::VAL_W];
		if (mode_s1 == ccp_pkg::MODE_NARROW) begin
			value = quot & ccp_pkg::NARROW_MASK;
		end else begin
			value = quot & ccp_pkg::WIDE_MASK;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			coef_s1 <= coefficient;
			mode_s1 <= mode;
		end
		if (adv_s2 && valid_s1) begin
			mode_s2  <= mode_s1;
			value_s2 <= value;
		end
	end

	assign cval.valid = valid_s2;
	assign cval.mode  = mode_s2;
	assign cval.value = value_s2;

endmodule

// ===== hw/rtl/ccp_packer.sv =====
module ccp_packer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ccp_pkg::cval_t             cval,
	output logic                       take,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ccp_pkg::BYTE_W-1:0] packed_byte,
	output logic                       run_last
);

	logic [ccp_pkg::BUF_W-1:0]  buf_q;
	logic [ccp_pkg::CNT_W-1:0]  cnt_q;
	logic                       out_valid_q;
	logic [ccp_pkg::BYTE_W-1:0] byte_q;
	logic                       last_q;

	logic                       free;
	logic                       emit;
	logic [ccp_pkg::CNT_W-1:0]  cnt_eff;
	logic [ccp_pkg::BUF_W-1:0]  buf_eff;
	logic [ccp_pkg::CNT_W-1:0]  width;
	logic [ccp_pkg::BUF_W-1:0]  buf_next;
	logic [ccp_pkg::CNT_W-1:0]  cnt_next;

	// byte emission and append of the next compressed value
	always_comb begin
		free = !out_valid_q || !out_stall;
		emit = free && (cnt_q >= ccp_pkg::CNT_W'(ccp_pkg::BYTE_W));
		if (emit) begin
			cnt_eff = cnt_q - ccp_pkg::CNT_W'(ccp_pkg::BYTE_W);
			buf_eff = buf_q >> ccp_pkg::BYTE_W;
		end else begin
			cnt_eff = cnt_q;
			buf_eff = buf_q;
		end
		take = cval.valid && (cnt_eff < ccp_pkg::CNT_W'(ccp_pkg::BYTE_W));
		if (cval.mode == ccp_pkg::MODE_NARROW) begin
			width = ccp_pkg::CNT_W'(ccp_pkg::NARROW_BITS);
		end else begin
			width = ccp_pkg::CNT_W'(ccp_pkg::WIDE_BITS);
		end
		if (take) begin
			buf_next = buf_eff | (ccp_pkg::BUF_W'(cval.value) << cnt_eff[2:0]);
			cnt_next = cnt_eff + width;
		end else begin
			buf_next = buf_eff;
			cnt_next = cnt_eff;
		end
	end

	// bit accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			buf_q <= buf_next;
			cnt_q <= cnt_next;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, last byte of the item when fewer than two bytes are pending
	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= buf_q[ccp_pkg::BYTE_W-1:0];
			last_q <= cnt_q < ccp_pkg::CNT_W'(2 * ccp_pkg::BYTE_W);
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = byte_q;
	assign run_last    = last_q;

endmodule

// ===== hw/rtl/coeff_compress_pack.sv =====
// Compresses one coefficient per item to 10 bits (compress_mode 0) or 3 bits
// (compress_mode 1) by rounding (x*2^d)/MODULUS with a constant reciprocal
// multiply, then packs the values LSB first into bytes; run_last marks the
// last byte an item produces. While the output keeps up, 3-bit items are
// taken one per cycle; 10-bit items are held back while a full byte is still
// pending. The single byte-wide output register moves one byte per cycle
// unless out_stall holds it. An item's first byte passes through the input
// register, multiply register, bit accumulator, then the output register.
// Write compress_mode only while idle; pending bits are kept across a change.
module coeff_compress_pack #(
	parameter int MODULUS = 7681
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       compress_mode,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ccp_pkg::COEF_W-1:0] coefficient,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ccp_pkg::BYTE_W-1:0] packed_byte,
	output logic                       run_last
);

	ccp_pkg::mode_t compress_mode_q;
	ccp_pkg::cval_t cval;
	logic           take;

	// mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compress_mode_q <= ccp_pkg::MODE_WIDE;
		end else if (cfg_valid && cfg_ready) begin
			compress_mode_q <= ccp_pkg::mode_t'(compress_mode);
		end
	end

	// compression pipeline
	ccp_compress #(
		.MODULUS (MODULUS)
	) u_compress (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coefficient (coefficient),
		.mode        (compress_mode_q),
		.cval        (cval),
		.take        (take)
	);

	// byte packer
	ccp_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cval        (cval),
		.take        (take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packed_byte (packed_byte),
		.run_last    (run_last)
	);

`ifndef SYNTHESIS
	// second byte of an item follows right after the first is taken
	a_second_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("second byte of an item did not follow");

	// narrow values carry only three bits
	a_narrow_value: assert property (@(posedge clk) disable iff (!arst_n)
		cval.valid && cval.mode == ccp_pkg::MODE_NARROW |-> cval.value[9:3] == 7'd0)
		else $error("narrow compressed value out of range");

	// a compressed value held back by the packer stays put
	a_cval_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cval.valid && !take |=> cval.valid && $stable(cval.value) && $stable(cval.mode))
		else $error("compressed value changed while held");
`endif

endmodule
